### hdl/keyword_operator_lexer_unit_assert.svh
// ----------------------------------------------------------------------------
// Keyword operator lexer assertion macros
// Shared clocked assertion forms used by the lexer modules.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_OPERATOR_LEXER_UNIT_ASSERT_SVH
`define KEYWORD_OPERATOR_LEXER_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define KOL_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: lexer check failed");

// Condition that must never be true outside of reset.
`define KOL_ASSERT_NEVER(lbl, cond) \
  `KOL_ASSERT_CLK(lbl, !(cond))

`endif

### hdl/kol_pkg.sv
// ----------------------------------------------------------------------------
// Keyword operator lexer package
// Token class codes, character codes, keyword table and result types.
// ----------------------------------------------------------------------------
package kol_pkg;

  localparam int LINE_MAX_DEF = 4096;
  localparam int NUM_BITS_DEF = 32;
  localparam int RQ_DEPTH     = 4;
  localparam int WORD_KEEP    = 5;

  // Token class codes.
  localparam logic [4:0] CLS_HASH          = 5'd0;
  localparam logic [4:0] CLS_BEGIN         = 5'd1;
  localparam logic [4:0] CLS_IF            = 5'd2;
  localparam logic [4:0] CLS_THEN          = 5'd3;
  localparam logic [4:0] CLS_WHILE         = 5'd4;
  localparam logic [4:0] CLS_DO            = 5'd5;
  localparam logic [4:0] CLS_END           = 5'd6;
  localparam logic [4:0] CLS_IDENT         = 5'd10;
  localparam logic [4:0] CLS_NUMBER        = 5'd11;
  localparam logic [4:0] CLS_PLUS          = 5'd13;
  localparam logic [4:0] CLS_MINUS         = 5'd14;
  localparam logic [4:0] CLS_STAR          = 5'd15;
  localparam logic [4:0] CLS_SLASH         = 5'd16;
  localparam logic [4:0] CLS_COLON         = 5'd17;
  localparam logic [4:0] CLS_ASSIGN        = 5'd18;
  localparam logic [4:0] CLS_LESS          = 5'd20;
  localparam logic [4:0] CLS_NOT_EQUAL     = 5'd21;
  localparam logic [4:0] CLS_LESS_EQUAL    = 5'd22;
  localparam logic [4:0] CLS_GREATER       = 5'd23;
  localparam logic [4:0] CLS_GREATER_EQUAL = 5'd24;
  localparam logic [4:0] CLS_EQUAL         = 5'd25;
  localparam logic [4:0] CLS_SEMI          = 5'd26;
  localparam logic [4:0] CLS_LPAREN        = 5'd27;
  localparam logic [4:0] CLS_RPAREN        = 5'd28;
  localparam logic [4:0] CLS_UNKNOWN       = 5'd29;

  // Character codes.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;

  // Keywords packed as right-aligned byte strings.
  localparam logic [39:0] KW_BEGIN = 40'h62_65_67_69_6E;
  localparam logic [39:0] KW_IF    = 40'h00_00_00_69_66;
  localparam logic [39:0] KW_THEN  = 40'h00_74_68_65_6E;
  localparam logic [39:0] KW_WHILE = 40'h77_68_69_6C_65;
  localparam logic [39:0] KW_DO    = 40'h00_00_00_64_6F;
  localparam logic [39:0] KW_END   = 40'h00_00_65_6E_64;

  typedef enum logic [5:0] {
    K_NONE    = 6'b000001,
    K_WORD    = 6'b000010,
    K_NUM     = 6'b000100,
    K_COLON   = 6'b001000,
    K_LESS    = 6'b010000,
    K_GREATER = 6'b100000
  } kind_t;

  typedef struct packed {
    logic [4:0]  cls;
    logic [11:0] start;
    logic [12:0] len;
    logic [31:0] value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } rq_push_t;

  function automatic logic [4:0] word_class(logic [39:0] prefix, logic [2:0] len3);
    logic [4:0] cls;
    cls = CLS_IDENT;
    if (len3 == 3'd5 && prefix == KW_BEGIN) begin
      cls = CLS_BEGIN;
    end else if (len3 == 3'd2 && prefix == KW_IF) begin
      cls = CLS_IF;
    end else if (len3 == 3'd4 && prefix == KW_THEN) begin
      cls = CLS_THEN;
    end else if (len3 == 3'd5 && prefix == KW_WHILE) begin
      cls = CLS_WHILE;
    end else if (len3 == 3'd2 && prefix == KW_DO) begin
      cls = CLS_DO;
    end else if (len3 == 3'd3 && prefix == KW_END) begin
      cls = CLS_END;
    end
    return cls;
  endfunction

  function automatic logic [4:0] single_class(logic [7:0] c);
    logic [4:0] cls;
    case (c)
      CH_HASH:   cls = CLS_HASH;
      CH_PLUS:   cls = CLS_PLUS;
      CH_MINUS:  cls = CLS_MINUS;
      CH_STAR:   cls = CLS_STAR;
      CH_SLASH:  cls = CLS_SLASH;
      CH_EQUAL:  cls = CLS_EQUAL;
      CH_SEMI:   cls = CLS_SEMI;
      CH_LPAREN: cls = CLS_LPAREN;
      CH_RPAREN: cls = CLS_RPAREN;
      default:   cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

endpackage

### hdl/keyword_operator_lexer_unit.sv
// ----------------------------------------------------------------------------
// Keyword operator lexer
// Streaming tokenizer for keywords, identifiers, numbers and operators.
// ----------------------------------------------------------------------------
// The input channel carries one character per transaction, with a flag on
// the last character of a line. The output channel carries one token per
// transaction: class, start position, length, number value and a flag on
// the last token produced by a given character. A character yields zero,
// one or two tokens.
// One character is accepted per cycle while in_ready is high. The lexer
// state is updated in the cycle of acceptance and the tokens are written
// into a four-entry result queue, whose registered head drives the output.
// in_ready is high while the queue holds at most two tokens. A stalled
// receiver lets the queue fill, and once three or more tokens wait the
// input is held off until the receiver drains it. The output drains at one
// token per cycle while out_ready is high.
// A synchronous active-low reset empties the queue, drops any pending
// token and sets the character position to zero.
// ----------------------------------------------------------------------------
module keyword_operator_lexer_unit #(
  parameter int LINE_MAX = kol_pkg::LINE_MAX_DEF,
  parameter int NUM_BITS = kol_pkg::NUM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_class,
  output logic [11:0] out_token_start,
  output logic [12:0] out_token_length,
  output logic [31:0] out_number_value,
  output logic        out_last_of_run
);

  localparam int POS_W = $clog2(LINE_MAX);
  localparam int LEN_W = $clog2(LINE_MAX + 1);

  kol_pkg::kind_t      kind_r, kind_nxt, step_kind;
  logic [39:0]         prefix_r, prefix_nxt;
  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0]    begin_r, begin_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt, len_grow;
  logic [POS_W-1:0]    pos_r, pos_nxt;

  logic                in_fire;
  logic                is_letter, is_digit;
  logic [3:0]          digit;
  logic [NUM_BITS+3:0] acc_prod;
  logic [NUM_BITS-1:0] acc_added;
  logic [4:0]          pair_cls;
  logic                old_pending;
  logic                a_vld, b_vld, single_vld;
  kol_pkg::res_t       old_tok, new_tok, pair_tok, single_tok, res_a, res_b;
  kol_pkg::rq_push_t   push;
  kol_pkg::res_t       head;
  logic                room2;

  function automatic kol_pkg::res_t make_tok(kol_pkg::kind_t kind, logic [39:0] prefix,
                                             logic [NUM_BITS-1:0] acc,
                                             logic [POS_W-1:0] start,
                                             logic [LEN_W-1:0] len);
    kol_pkg::res_t t;
    logic [31:0]   start_w;
    logic [31:0]   len_w;
    logic [63:0]   acc_w;
    logic [2:0]    len3;
    start_w = 32'(start);
    len_w   = 32'(len);
    acc_w   = 64'(acc);
    len3    = (len_w < 32'd8) ? len_w[2:0] : 3'd0;
    t       = '0;
    t.start = start_w[11:0];
    t.len   = len_w[12:0];
    case (kind)
      kol_pkg::K_WORD: begin
        t.cls = kol_pkg::word_class(prefix, len3);
      end
      kol_pkg::K_NUM: begin
        t.cls   = kol_pkg::CLS_NUMBER;
        t.value = acc_w[31:0];
      end
      kol_pkg::K_COLON:   t.cls = kol_pkg::CLS_COLON;
      kol_pkg::K_LESS:    t.cls = kol_pkg::CLS_LESS;
      kol_pkg::K_GREATER: t.cls = kol_pkg::CLS_GREATER;
      default:            t.cls = kol_pkg::CLS_UNKNOWN;
    endcase
    return t;
  endfunction

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = room2;
  assign is_letter = (in_char_in >= kol_pkg::CH_LOW_A) && (in_char_in <= kol_pkg::CH_LOW_Z);
  assign is_digit  = (in_char_in >= kol_pkg::CH_ZERO) && (in_char_in <= kol_pkg::CH_NINE);
  assign digit     = 4'(in_char_in - kol_pkg::CH_ZERO);
  assign len_grow  = (len_r < LEN_W'(LINE_MAX)) ? len_r + LEN_W'(1) : len_r;

  // Saturating decimal accumulate: acc * 10 + digit.
  always_comb begin
    acc_prod  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + (NUM_BITS + 4)'(digit);
    acc_added = (acc_prod[NUM_BITS+3:NUM_BITS] != 4'd0) ? '1 : acc_prod[NUM_BITS-1:0];
  end

  always_comb begin
    pair_cls = 5'd0;
    if (kind_r == kol_pkg::K_COLON && in_char_in == kol_pkg::CH_EQUAL) begin
      pair_cls = kol_pkg::CLS_ASSIGN;
    end else if (kind_r == kol_pkg::K_LESS && in_char_in == kol_pkg::CH_GREATER) begin
      pair_cls = kol_pkg::CLS_NOT_EQUAL;
    end else if (kind_r == kol_pkg::K_LESS && in_char_in == kol_pkg::CH_EQUAL) begin
      pair_cls = kol_pkg::CLS_LESS_EQUAL;
    end else if (kind_r == kol_pkg::K_GREATER && in_char_in == kol_pkg::CH_EQUAL) begin
      pair_cls = kol_pkg::CLS_GREATER_EQUAL;
    end
  end

  assign old_pending = (kind_r != kol_pkg::K_NONE);
  assign old_tok     = make_tok(kind_r, prefix_r, acc_r, begin_r, len_r);

  always_comb begin
    pair_tok       = '0;
    pair_tok.cls   = pair_cls;
    pair_tok.start = 12'(32'(begin_r));
    pair_tok.len   = 13'd2;
    single_tok       = '0;
    single_tok.cls   = kol_pkg::single_class(in_char_in);
    single_tok.start = 12'(32'(pos_r));
    single_tok.len   = 13'd1;
  end

  // Per-character state update before the end-of-line flush.
  always_comb begin
    step_kind  = kind_r;
    prefix_nxt = prefix_r;
    acc_nxt    = acc_r;
    begin_nxt  = begin_r;
    len_nxt    = len_r;
    a_vld      = 1'b0;
    single_vld = 1'b0;
    if (pair_cls != 5'd0) begin
      a_vld     = 1'b1;
      step_kind = kol_pkg::K_NONE;
    end else if (is_letter || (is_digit && kind_r == kol_pkg::K_WORD)) begin
      if (kind_r != kol_pkg::K_WORD) begin
        a_vld      = old_pending;
        step_kind  = kol_pkg::K_WORD;
        begin_nxt  = pos_r;
        len_nxt    = LEN_W'(1);
        prefix_nxt = 40'(in_char_in);
        acc_nxt    = '0;
      end else begin
        if (len_r < LEN_W'(kol_pkg::WORD_KEEP)) begin
          prefix_nxt = {prefix_r[31:0], in_char_in};
        end
        len_nxt = len_grow;
      end
    end else if (is_digit) begin
      if (kind_r != kol_pkg::K_NUM) begin
        a_vld      = old_pending;
        step_kind  = kol_pkg::K_NUM;
        begin_nxt  = pos_r;
        len_nxt    = LEN_W'(1);
        prefix_nxt = '0;
        acc_nxt    = NUM_BITS'(digit);
      end else begin
        len_nxt = len_grow;
        acc_nxt = acc_added;
      end
    end else if (in_char_in == kol_pkg::CH_SPACE) begin
      a_vld     = old_pending;
      step_kind = kol_pkg::K_NONE;
    end else if (in_char_in == kol_pkg::CH_COLON || in_char_in == kol_pkg::CH_LESS ||
                 in_char_in == kol_pkg::CH_GREATER) begin
      a_vld      = old_pending;
      begin_nxt  = pos_r;
      len_nxt    = LEN_W'(1);
      prefix_nxt = '0;
      acc_nxt    = '0;
      if (in_char_in == kol_pkg::CH_COLON) begin
        step_kind = kol_pkg::K_COLON;
      end else if (in_char_in == kol_pkg::CH_LESS) begin
        step_kind = kol_pkg::K_LESS;
      end else begin
        step_kind = kol_pkg::K_GREATER;
      end
    end else begin
      a_vld      = old_pending;
      single_vld = 1'b1;
      step_kind  = kol_pkg::K_NONE;
    end
  end

  assign new_tok = make_tok(step_kind, prefix_nxt, acc_nxt, begin_nxt, len_nxt);

  // End of line flushes pending work; position wraps there and at LINE_MAX.
  always_comb begin
    kind_nxt = step_kind;
    b_vld    = single_vld;
    res_b    = single_tok;
    res_a    = (pair_cls != 5'd0) ? pair_tok : old_tok;
    if (in_end_of_line && step_kind != kol_pkg::K_NONE) begin
      b_vld    = 1'b1;
      res_b    = new_tok;
      kind_nxt = kol_pkg::K_NONE;
    end
    res_a.last = !b_vld;
    res_b.last = 1'b1;
    if (in_end_of_line || pos_r == POS_W'(LINE_MAX - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_comb begin
    push.first  = a_vld ? res_a : res_b;
    push.second = res_b;
    push.cnt    = in_fire ? (2'(a_vld) + 2'(b_vld)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= kol_pkg::K_NONE;
      prefix_r <= '0;
      acc_r    <= '0;
      begin_r  <= '0;
      len_r    <= '0;
      pos_r    <= '0;
    end else if (in_fire) begin
      kind_r   <= kind_nxt;
      prefix_r <= prefix_nxt;
      acc_r    <= acc_nxt;
      begin_r  <= begin_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
    end
  end

  kol_result_queue u_result_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .head_o      (head)
  );

  assign out_token_class  = head.cls;
  assign out_token_start  = head.start;
  assign out_token_length = head.len;
  assign out_number_value = head.value;
  assign out_last_of_run  = head.last;

  `include "keyword_operator_lexer_unit_assert.svh"

  `KOL_ASSERT_CLK(a_eol_clears, (in_fire && in_end_of_line) |=> (kind_r == kol_pkg::K_NONE && pos_r == '0))
  `KOL_ASSERT_NEVER(a_pending_len, (kind_r != kol_pkg::K_NONE) && (len_r == '0))
  `KOL_ASSERT_CLK(a_pair_done, (in_fire && pair_cls != 5'd0) |=> (kind_r == kol_pkg::K_NONE))

endmodule

### hdl/kol_result_queue.sv
// ----------------------------------------------------------------------------
// Keyword operator lexer result queue
// Small queue taking up to two tokens per cycle, giving one per ready cycle.
// ----------------------------------------------------------------------------
module kol_result_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  kol_pkg::rq_push_t push_i,
  output logic              room2_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kol_pkg::res_t     head_o
);

  localparam int PTR_W = $clog2(kol_pkg::RQ_DEPTH);
  localparam int CNT_W = $clog2(kol_pkg::RQ_DEPTH + 1);

  kol_pkg::res_t    mem_r [kol_pkg::RQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign out_valid_o = (count_r != '0);
  assign head_o      = mem_r[rd_ptr_r];
  assign room2_o     = (count_r <= CNT_W'(kol_pkg::RQ_DEPTH - 2));
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_i.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_i.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= push_i.second;
    end
  end

  `include "keyword_operator_lexer_unit_assert.svh"

  `KOL_ASSERT_NEVER(a_rq_overflow, count_r > CNT_W'(kol_pkg::RQ_DEPTH))
  `KOL_ASSERT_NEVER(a_rq_push_full, (push_i.cnt != 2'd0) && !room2_o)
  `KOL_ASSERT_CLK(a_rq_drain, (pop && count_r == CNT_W'(1) && push_i.cnt == 2'd0) |=> !out_valid_o)

endmodule
